// ===== design/odc_pkg.sv =====
// ----------------------------------------------------------------------------
// odc_pkg
// Types and constants shared by the obstacle-aware drive command block.
// ----------------------------------------------------------------------------
package odc_pkg;

    localparam int ADDR_W    = 5;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 16;
    localparam int CLEAR_W   = 10;
    localparam int DIST_W    = 16;

    // Drive commands
    typedef enum logic [3:0] {
        CMD_STOP     = 4'd0,
        CMD_SLOWDOWN = 4'd1,
        CMD_LEFT     = 4'd2,
        CMD_RIGHT    = 4'd3,
        CMD_NEUTRAL  = 4'd4,
        CMD_REVERSE  = 4'd5,
        CMD_FORWARD  = 4'd6,
        CMD_LIGHTS   = 4'd7,
        CMD_NONE     = 4'd8
    } cmd_t;

    typedef enum logic [1:0] {
        STEER_NEUTRAL = 2'd0,
        STEER_LEFT    = 2'd1,
        STEER_RIGHT   = 2'd2
    } steer_t;

    localparam logic [2:0] SPEED_STOP  = 3'd0;
    localparam logic [2:0] SPEED_ONE   = 3'd1;
    localparam logic [2:0] SPEED_TWO   = 3'd2;
    localparam logic [2:0] SPEED_THREE = 3'd3;
    localparam logic [2:0] SPEED_FOUR  = 3'd4;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_NEAR_MIN   = 3'd0;
    localparam logic [2:0] REG_NEAR_MAX   = 3'd1;
    localparam logic [2:0] REG_BAND_ONE   = 3'd2;
    localparam logic [2:0] REG_BAND_TWO   = 3'd3;
    localparam logic [2:0] REG_BAND_THREE = 3'd4;
    localparam logic [2:0] REG_TURN_CLR   = 3'd5;
    localparam logic [2:0] REG_DODGE_CLR  = 3'd6;
    localparam logic [2:0] REG_REAR_CLR   = 3'd7;

    localparam logic [DIST_W-1:0]  NEAR_MIN_RST   = 16'd2;
    localparam logic [DIST_W-1:0]  NEAR_MAX_RST   = 16'd100;
    localparam logic [DIST_W-1:0]  BAND_ONE_RST   = 16'd300;
    localparam logic [DIST_W-1:0]  BAND_TWO_RST   = 16'd400;
    localparam logic [DIST_W-1:0]  BAND_THREE_RST = 16'd500;
    localparam logic [CLEAR_W-1:0] TURN_CLR_RST   = 10'd30;
    localparam logic [CLEAR_W-1:0] DODGE_CLR_RST  = 10'd50;
    localparam logic [CLEAR_W-1:0] REAR_CLR_RST   = 10'd50;

    typedef struct packed {
        logic [DIST_W-1:0] near_min;
        logic [DIST_W-1:0] near_max;
        logic [DIST_W-1:0] band_one;
        logic [DIST_W-1:0] band_two;
        logic [DIST_W-1:0] band_three;
    } band_cfg_t;

    typedef struct packed {
        logic              mode_valid;
        logic [3:0]        mode;
        logic [DIST_W-1:0] front_cm;
        logic [DIST_W-1:0] left_echo_ticks;
        logic [DIST_W-1:0] right_echo_ticks;
        logic [DIST_W-1:0] rear_echo_ticks;
    } item_t;

    typedef struct packed {
        logic [2:0] speed_level;
        logic       reverse_dir;
        logic [1:0] steer_pos;
        logic       motor_write;
        logic       steer_write;
        logic       lights_on;
    } result_t;

endpackage

// ===== design/obstacle_aware_drive_command_core.sv =====
// ----------------------------------------------------------------------------
// obstacle_aware_drive_command_core
// Drive command loop: input register, one pass of decision logic, result
// register, loaded when the result stage is free. Throughput 1 word per
// cycle while m_tready does not stall the output; the decision logic sits
// between the two registers and the control state updates as each word
// moves to the output. Asynchronous active-low reset clears state, latches
// and valids; registers return to their documented defaults.
// ----------------------------------------------------------------------------
module obstacle_aware_drive_command_core
    import odc_pkg::*;
#(
    parameter int ECHO_DIVISOR = 116
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [3:0] mode, [19:4] front_cm, [35:20] left_echo_ticks,
    // [51:36] right_echo_ticks, [67:52] rear_echo_ticks, [71:68] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] mode_valid
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] speed_level, [3] reverse_dir, [5:4] steer_pos, [6] motor_write,
    // [7] steer_write, [8] lights_on, [15:9] zero
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int DIV_EFF = (ECHO_DIVISOR == 0) ? 1 : ECHO_DIVISOR;
    localparam int DIV_W   = $clog2(DIV_EFF + 1);
    localparam int THR_W   = (CLEAR_W + 1 + DIV_W > DIST_W) ? CLEAR_W + 1 + DIV_W : DIST_W;

    band_cfg_t        band;
    logic [THR_W-1:0] turn_thr, dodge_thr, rear_thr;

    item_t   in_item;
    item_t   item_reg;
    logic    s1_valid_reg;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    out_free;
    logic    advance;

    odc_cfg_regs #(
        .DIV_EFF (DIV_EFF),
        .THR_W   (THR_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .band      (band),
        .turn_thr  (turn_thr),
        .dodge_thr (dodge_thr),
        .rear_thr  (rear_thr)
    );

    assign pready = 1'b1;

    assign in_item.mode_valid       = s_tuser;
    assign in_item.mode             = s_tdata[3:0];
    assign in_item.front_cm         = s_tdata[19:4];
    assign in_item.left_echo_ticks  = s_tdata[35:20];
    assign in_item.right_echo_ticks = s_tdata[51:36];
    assign in_item.rear_echo_ticks  = s_tdata[67:52];

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                s1_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            item_reg <= in_item;
        if (advance)
            res_reg <= res;
    end

    odc_step #(
        .THR_W (THR_W)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .item      (item_reg),
        .band      (band),
        .turn_thr  (turn_thr),
        .dodge_thr (dodge_thr),
        .rear_thr  (rear_thr),
        .res       (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, res_reg.lights_on, res_reg.steer_write, res_reg.motor_write,
                       res_reg.steer_pos, res_reg.reverse_dir, res_reg.speed_level};

`ifndef NO_ASSERTIONS
    // lights latch never drops once shown
    a_lights_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.lights_on |=> res_reg.lights_on)
        else $error("lights latch dropped");

    // a word in the input stage waits until the result stage frees up
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(item_reg))
        else $error("input stage word lost");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_reg.speed_level <= SPEED_FOUR)
        else $error("speed level out of range");
`endif

endmodule

// ===== design/odc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// odc_cfg_regs
// APB register file for distance bands and clearances. Echo-tick thresholds
// are worked out at write time so the datapath needs no divider.
// ----------------------------------------------------------------------------
module odc_cfg_regs
    import odc_pkg::*;
#(
    parameter int DIV_EFF = 116,
    parameter int THR_W   = 18
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output band_cfg_t             band,
    output logic [THR_W-1:0]      turn_thr,
    output logic [THR_W-1:0]      dodge_thr,
    output logic [THR_W-1:0]      rear_thr
);

    // floor(ticks / D) > c  <=>  ticks >= (c + 1) * D
    localparam logic [THR_W-1:0] DIV_C      = THR_W'(DIV_EFF);
    localparam logic [THR_W-1:0] TURN_RST_T = THR_W'((int'(TURN_CLR_RST) + 1) * DIV_EFF);
    localparam logic [THR_W-1:0] DODGE_RST_T = THR_W'((int'(DODGE_CLR_RST) + 1) * DIV_EFF);
    localparam logic [THR_W-1:0] REAR_RST_T = THR_W'((int'(REAR_CLR_RST) + 1) * DIV_EFF);

    band_cfg_t          band_reg;
    logic [CLEAR_W-1:0] turn_clr_reg;
    logic [CLEAR_W-1:0] dodge_clr_reg;
    logic [CLEAR_W-1:0] rear_clr_reg;
    logic [THR_W-1:0]   turn_thr_reg;
    logic [THR_W-1:0]   dodge_thr_reg;
    logic [THR_W-1:0]   rear_thr_reg;
    logic               wr_en;
    logic [2:0]         reg_idx;
    logic [THR_W-1:0]   wr_thr;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign wr_thr  = (THR_W'(pwdata[CLEAR_W-1:0]) + THR_W'(1)) * DIV_C;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg.near_min   <= NEAR_MIN_RST;
            band_reg.near_max   <= NEAR_MAX_RST;
            band_reg.band_one   <= BAND_ONE_RST;
            band_reg.band_two   <= BAND_TWO_RST;
            band_reg.band_three <= BAND_THREE_RST;
            turn_clr_reg        <= TURN_CLR_RST;
            dodge_clr_reg       <= DODGE_CLR_RST;
            rear_clr_reg        <= REAR_CLR_RST;
            turn_thr_reg        <= TURN_RST_T;
            dodge_thr_reg       <= DODGE_RST_T;
            rear_thr_reg        <= REAR_RST_T;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_NEAR_MIN:   band_reg.near_min   <= pwdata[DIST_W-1:0];
                REG_NEAR_MAX:   band_reg.near_max   <= pwdata[DIST_W-1:0];
                REG_BAND_ONE:   band_reg.band_one   <= pwdata[DIST_W-1:0];
                REG_BAND_TWO:   band_reg.band_two   <= pwdata[DIST_W-1:0];
                REG_BAND_THREE: band_reg.band_three <= pwdata[DIST_W-1:0];
                REG_TURN_CLR:
                begin
                    turn_clr_reg <= pwdata[CLEAR_W-1:0];
                    turn_thr_reg <= wr_thr;
                end
                REG_DODGE_CLR:
                begin
                    dodge_clr_reg <= pwdata[CLEAR_W-1:0];
                    dodge_thr_reg <= wr_thr;
                end
                REG_REAR_CLR:
                begin
                    rear_clr_reg <= pwdata[CLEAR_W-1:0];
                    rear_thr_reg <= wr_thr;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_NEAR_MIN:   prdata = 32'(band_reg.near_min);
            REG_NEAR_MAX:   prdata = 32'(band_reg.near_max);
            REG_BAND_ONE:   prdata = 32'(band_reg.band_one);
            REG_BAND_TWO:   prdata = 32'(band_reg.band_two);
            REG_BAND_THREE: prdata = 32'(band_reg.band_three);
            REG_TURN_CLR:   prdata = 32'(turn_clr_reg);
            REG_DODGE_CLR:  prdata = 32'(dodge_clr_reg);
            REG_REAR_CLR:   prdata = 32'(rear_clr_reg);
            default:        prdata = 32'd0;
        endcase
    end

    assign band      = band_reg;
    assign turn_thr  = turn_thr_reg;
    assign dodge_thr = dodge_thr_reg;
    assign rear_thr  = rear_thr_reg;

endmodule

// ===== design/odc_step.sv =====
// ----------------------------------------------------------------------------
// odc_step
// Control state and the decision logic of one loop pass. State is updated
// when step_en is high; res is the result of the pass in flight.
// ----------------------------------------------------------------------------
module odc_step
    import odc_pkg::*;
#(
    parameter int THR_W = 18
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  item_t            item,
    input  band_cfg_t        band,
    input  logic [THR_W-1:0] turn_thr,
    input  logic [THR_W-1:0] dodge_thr,
    input  logic [THR_W-1:0] rear_thr,
    output result_t          res
);

    cmd_t       held_reg,   held_next;
    steer_t     steer_reg,  steer_next;
    logic [2:0] speed_reg,  speed_next;
    logic       dir_reg,    dir_next;
    logic       stop_reg,   stop_next;
    logic       lights_reg, lights_next;

    cmd_t             cmd;
    logic [THR_W-1:0] left_t, right_t, rear_t;
    logic             near;
    logic             left_turn_ok, right_turn_ok, left_dodge_ok, right_dodge_ok;
    logic             rear_clear, side_ok;
    logic             mw;

    assign cmd    = item.mode_valid ? cmd_t'(item.mode) : held_reg;
    assign left_t = THR_W'(item.left_echo_ticks);
    assign right_t = THR_W'(item.right_echo_ticks);
    assign rear_t = THR_W'(item.rear_echo_ticks);

    assign near = (item.front_cm >= band.near_min) && (item.front_cm <= band.near_max);
    assign left_turn_ok   = left_t  >= turn_thr;
    assign right_turn_ok  = right_t >= turn_thr;
    assign left_dodge_ok  = left_t  >= dodge_thr;
    assign right_dodge_ok = right_t >= dodge_thr;
    assign rear_clear     = rear_t  >= rear_thr;
    assign side_ok        = (cmd == CMD_LEFT) ? left_turn_ok : right_turn_ok;

    always_comb
    begin
        held_next   = cmd;
        steer_next  = steer_reg;
        speed_next  = speed_reg;
        dir_next    = dir_reg;
        stop_next   = stop_reg;
        lights_next = lights_reg;
        mw          = 1'b0;
        case (cmd)
            CMD_STOP:
            begin
                if (!stop_reg)
                begin
                    if (rear_clear)
                    begin
                        speed_next = SPEED_STOP;
                        stop_next  = 1'b1;
                    end
                    else
                    begin
                        speed_next = SPEED_ONE;
                    end
                    dir_next = 1'b0;
                    mw       = 1'b1;
                end
            end
            CMD_SLOWDOWN:
            begin
                if (item.front_cm > band.near_max && item.front_cm < band.band_one)
                    speed_next = SPEED_ONE;
                else if (near)
                    speed_next = SPEED_STOP;
                else
                    speed_next = SPEED_TWO;
                dir_next = 1'b0;
                mw       = 1'b1;
            end
            CMD_LEFT, CMD_RIGHT:
            begin
                if (side_ok)
                begin
                    steer_next = (cmd == CMD_LEFT) ? STEER_LEFT : STEER_RIGHT;
                    speed_next = near ? SPEED_STOP : SPEED_TWO;
                end
                else
                begin
                    steer_next = STEER_NEUTRAL;
                    speed_next = near ? SPEED_STOP : SPEED_ONE;
                end
                dir_next = 1'b0;
                mw       = 1'b1;
            end
            CMD_NEUTRAL:
            begin
                // straightening out hands over to forward driving
                if (steer_reg != STEER_NEUTRAL)
                begin
                    steer_next = STEER_NEUTRAL;
                    held_next  = CMD_FORWARD;
                end
            end
            CMD_REVERSE:
            begin
                speed_next = rear_clear ? SPEED_ONE : SPEED_STOP;
                dir_next   = 1'b1;
                mw         = 1'b1;
            end
            CMD_FORWARD:
            begin
                stop_next = 1'b0;
                if (near)
                begin
                    if (left_dodge_ok)
                    begin
                        steer_next = STEER_LEFT;
                        speed_next = SPEED_ONE;
                    end
                    else if (right_dodge_ok)
                    begin
                        steer_next = STEER_RIGHT;
                        speed_next = SPEED_ONE;
                    end
                    else
                    begin
                        steer_next = STEER_NEUTRAL;
                        speed_next = SPEED_STOP;
                    end
                end
                else
                begin
                    steer_next = STEER_NEUTRAL;
                    if (item.front_cm > band.near_max && item.front_cm <= band.band_one)
                        speed_next = SPEED_ONE;
                    else if (item.front_cm > band.band_one && item.front_cm <= band.band_two)
                        speed_next = SPEED_TWO;
                    else if (item.front_cm > band.band_two
                             && item.front_cm <= band.band_three)
                        speed_next = SPEED_THREE;
                    else
                        speed_next = SPEED_FOUR;
                end
                dir_next = 1'b0;
                mw       = 1'b1;
            end
            CMD_LIGHTS:
            begin
                lights_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= CMD_NONE;
            steer_reg  <= STEER_NEUTRAL;
            speed_reg  <= SPEED_STOP;
            dir_reg    <= 1'b0;
            stop_reg   <= 1'b0;
            lights_reg <= 1'b0;
        end
        else if (step_en)
        begin
            held_reg   <= held_next;
            steer_reg  <= steer_next;
            speed_reg  <= speed_next;
            dir_reg    <= dir_next;
            stop_reg   <= stop_next;
            lights_reg <= lights_next;
        end
    end

    assign res.speed_level = speed_next;
    assign res.reverse_dir = dir_next;
    assign res.steer_pos   = steer_next;
    assign res.motor_write = mw;
    assign res.steer_write = (steer_next != steer_reg);
    assign res.lights_on   = lights_next;

endmodule
